[hw/rtl/assert_macros.svh]
// Assertion helpers for the closest-point unit checkers.
// Every check samples on the rising edge of clk_i and sleeps while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TCPB_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tcpb check failed");

// Check a property only on edges where a result beat is offered.
`define TCPB_ASSERT_OUT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> (prop)) \
    else $error("tcpb result check failed");

`endif

[hw/rtl/tcpb_pkg.sv]
package tcpb_pkg;

  localparam int COORD_W  = 16;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int DOT_W    = PROD_W + 1;
  localparam int WIDE_W   = DOT_W + 3;
  localparam int DEN_W    = 34;
  localparam int REM_W    = DEN_W + 1;
  localparam int Q_W      = 16;
  localparam int REGION_W = 3;
  localparam int NUM_LANE = 3;

  localparam int GEOM_STG = 6;
  localparam int DIV_STG  = Q_W;
  localparam int NUM_STG  = GEOM_STG + DIV_STG;

  typedef enum logic [REGION_W-1:0] {
    REG_VERT_A   = 3'd0,
    REG_VERT_B   = 3'd1,
    REG_EDGE_AB  = 3'd2,
    REG_VERT_C   = 3'd3,
    REG_EDGE_AC  = 3'd4,
    REG_EDGE_BC  = 3'd5,
    REG_INTERIOR = 3'd6
  } region_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by_coord;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
  } in_item_t;

  typedef struct packed {
    logic [Q_W-1:0]      weight_a;
    logic [Q_W-1:0]      weight_b;
    logic [Q_W-1:0]      weight_c;
    logic [REGION_W-1:0] region;
    logic                degenerate;
  } out_item_t;

  // Handoff from the geometry front end to the divider lanes.
  typedef struct packed {
    region_e                          region;
    logic                             degen;
    logic [DEN_W-1:0]                 den;
    logic [NUM_LANE-1:0][REM_W-1:0]   rem;
  } div_in_t;

endpackage

[hw/rtl/tcpb_geom.sv]
module tcpb_geom (
  input  logic                                clk_i,
  input  logic [tcpb_pkg::GEOM_STG-1:0]       en_i,
  input  tcpb_pkg::in_item_t                  in_i,
  output tcpb_pkg::div_in_t                   out_o
);

  localparam int DIFF_W = tcpb_pkg::DIFF_W;
  localparam int PROD_W = tcpb_pkg::PROD_W;
  localparam int DOT_W  = tcpb_pkg::DOT_W;
  localparam int WIDE_W = tcpb_pkg::WIDE_W;
  localparam int DEN_W  = tcpb_pkg::DEN_W;
  localparam int REM_W  = tcpb_pkg::REM_W;
  localparam int NLANE  = tcpb_pkg::NUM_LANE;

  localparam int NUM_VEC   = 5;
  localparam int V_AB      = 0;
  localparam int V_AC      = 1;
  localparam int V_AP      = 2;
  localparam int V_BP      = 3;
  localparam int V_CP      = 4;
  localparam int NUM_DOT   = 6;
  localparam int NUM_CROSS = 3;
  localparam int X_N       = 0;
  localparam int X_CV      = 1;
  localparam int X_CW      = 2;

  localparam int STG_DIF = 0;
  localparam int STG_MUL = 1;
  localparam int STG_SUM = 2;
  localparam int STG_DER = 3;
  localparam int STG_SEL = 4;
  localparam int STG_CLP = 5;

  function automatic logic nonpos(logic signed [WIDE_W-1:0] x);
    return x[WIDE_W-1] || (x == '0);
  endfunction

  // Sign of f*g is not positive.
  function automatic logic prod_le0(logic signed [WIDE_W-1:0] f,
                                    logic signed [WIDE_W-1:0] g);
    return (f == '0) || (g == '0) || (f[WIDE_W-1] != g[WIDE_W-1]);
  endfunction

  // Edge vectors
  logic signed [DIFF_W-1:0] dx_q [NUM_VEC];
  logic signed [DIFF_W-1:0] dy_q [NUM_VEC];

  always_ff @(posedge clk_i) begin
    if (en_i[STG_DIF]) begin
      dx_q[V_AB] <= DIFF_W'(in_i.bx) - DIFF_W'(in_i.ax);
      dy_q[V_AB] <= DIFF_W'(in_i.by_coord) - DIFF_W'(in_i.ay);
      dx_q[V_AC] <= DIFF_W'(in_i.cx) - DIFF_W'(in_i.ax);
      dy_q[V_AC] <= DIFF_W'(in_i.cy) - DIFF_W'(in_i.ay);
      dx_q[V_AP] <= DIFF_W'(in_i.px) - DIFF_W'(in_i.ax);
      dy_q[V_AP] <= DIFF_W'(in_i.py) - DIFF_W'(in_i.ay);
      dx_q[V_BP] <= DIFF_W'(in_i.px) - DIFF_W'(in_i.bx);
      dy_q[V_BP] <= DIFF_W'(in_i.py) - DIFF_W'(in_i.by_coord);
      dx_q[V_CP] <= DIFF_W'(in_i.px) - DIFF_W'(in_i.cx);
      dy_q[V_CP] <= DIFF_W'(in_i.py) - DIFF_W'(in_i.cy);
    end
  end

  // Products
  logic signed [PROD_W-1:0] dot_q   [NUM_DOT][2];
  logic signed [PROD_W-1:0] cross_q [NUM_CROSS][2];

  always_ff @(posedge clk_i) begin
    if (en_i[STG_MUL]) begin
      dot_q[0][0] <= dx_q[V_AB] * dx_q[V_AP];
      dot_q[0][1] <= dy_q[V_AB] * dy_q[V_AP];
      dot_q[1][0] <= dx_q[V_AC] * dx_q[V_AP];
      dot_q[1][1] <= dy_q[V_AC] * dy_q[V_AP];
      dot_q[2][0] <= dx_q[V_AB] * dx_q[V_BP];
      dot_q[2][1] <= dy_q[V_AB] * dy_q[V_BP];
      dot_q[3][0] <= dx_q[V_AC] * dx_q[V_BP];
      dot_q[3][1] <= dy_q[V_AC] * dy_q[V_BP];
      dot_q[4][0] <= dx_q[V_AB] * dx_q[V_CP];
      dot_q[4][1] <= dy_q[V_AB] * dy_q[V_CP];
      dot_q[5][0] <= dx_q[V_AC] * dx_q[V_CP];
      dot_q[5][1] <= dy_q[V_AC] * dy_q[V_CP];
      cross_q[X_N][0]  <= dx_q[V_AB] * dy_q[V_AC];
      cross_q[X_N][1]  <= dy_q[V_AB] * dx_q[V_AC];
      cross_q[X_CV][0] <= dx_q[V_AP] * dy_q[V_AC];
      cross_q[X_CV][1] <= dy_q[V_AP] * dx_q[V_AC];
      cross_q[X_CW][0] <= dx_q[V_AB] * dy_q[V_AP];
      cross_q[X_CW][1] <= dy_q[V_AB] * dx_q[V_AP];
    end
  end

  // Dot and cross sums
  logic signed [DOT_W-1:0] d_q  [NUM_DOT];
  logic signed [DOT_W-1:0] cr_q [NUM_CROSS];

  always_ff @(posedge clk_i) begin
    if (en_i[STG_SUM]) begin
      for (int i = 0; i < NUM_DOT; i++) begin
        d_q[i] <= DOT_W'(dot_q[i][0]) + DOT_W'(dot_q[i][1]);
      end
      for (int i = 0; i < NUM_CROSS; i++) begin
        cr_q[i] <= DOT_W'(cross_q[i][0]) - DOT_W'(cross_q[i][1]);
      end
    end
  end

  // Derived terms and the early region tests
  logic signed [WIDE_W-1:0] d1_w, d2_w, d3_w, d6_w, n_w, cv_w, cw_w;
  logic signed [WIDE_W-1:0] ua_w, e43_w, e56_w;

  assign d1_w  = WIDE_W'(d_q[0]);
  assign d2_w  = WIDE_W'(d_q[1]);
  assign d3_w  = WIDE_W'(d_q[2]);
  assign d6_w  = WIDE_W'(d_q[5]);
  assign n_w   = WIDE_W'(cr_q[X_N]);
  assign cv_w  = WIDE_W'(cr_q[X_CV]);
  assign cw_w  = WIDE_W'(cr_q[X_CW]);
  assign ua_w  = n_w - cv_w - cw_w;
  assign e43_w = WIDE_W'(d_q[3]) - d3_w;
  assign e56_w = WIDE_W'(d_q[4]) - d6_w;

  logic signed [WIDE_W-1:0] d1_q, d2_q, d3_q, d6_q, n_q, cv_q, cw_q, ua_q, e43_q, e56_q;
  logic ca_q, cb_q, cab_q, cc_q, cac_q;

  always_ff @(posedge clk_i) begin
    if (en_i[STG_DER]) begin
      d1_q  <= d1_w;
      d2_q  <= d2_w;
      d3_q  <= d3_w;
      d6_q  <= d6_w;
      n_q   <= n_w;
      cv_q  <= cv_w;
      cw_q  <= cw_w;
      ua_q  <= ua_w;
      e43_q <= e43_w;
      e56_q <= e56_w;
      ca_q  <= nonpos(d1_w) && nonpos(d2_w);
      cb_q  <= !d3_w[WIDE_W-1] && nonpos(e43_w);
      cab_q <= prod_le0(n_w, cw_w) && !d1_w[WIDE_W-1] && nonpos(d3_w);
      cc_q  <= !d6_w[WIDE_W-1] && nonpos(e56_w);
      cac_q <= prod_le0(n_w, cv_w) && !d2_w[WIDE_W-1] && nonpos(d6_w);
    end
  end

  // Region pick, divisor and numerators per lane
  tcpb_pkg::region_e        region_s;
  logic                     degen_s;
  logic                     cbc_s;
  logic signed [WIDE_W-1:0] den_s;
  logic signed [WIDE_W-1:0] den_bc_s;
  logic signed [WIDE_W-1:0] num_s [NLANE];

  always_comb begin
    den_bc_s = e43_q + e56_q;
    cbc_s    = prod_le0(n_q, ua_q) && !e43_q[WIDE_W-1] && !e56_q[WIDE_W-1];
    region_s = tcpb_pkg::REG_INTERIOR;
    degen_s  = 1'b0;
    den_s    = WIDE_W'(1);
    for (int l = 0; l < NLANE; l++) begin
      num_s[l] = '0;
    end
    if (ca_q) begin
      region_s = tcpb_pkg::REG_VERT_A;
      num_s[0] = WIDE_W'(1);
    end else if (cb_q) begin
      region_s = tcpb_pkg::REG_VERT_B;
      num_s[1] = WIDE_W'(1);
    end else if (cab_q) begin
      region_s = tcpb_pkg::REG_EDGE_AB;
      den_s    = d1_q - d3_q;
      degen_s  = nonpos(den_s);
      num_s[0] = -d3_q;
      num_s[1] = d1_q;
    end else if (cc_q) begin
      region_s = tcpb_pkg::REG_VERT_C;
      num_s[2] = WIDE_W'(1);
    end else if (cac_q) begin
      region_s = tcpb_pkg::REG_EDGE_AC;
      den_s    = d2_q - d6_q;
      degen_s  = nonpos(den_s);
      num_s[0] = -d6_q;
      num_s[2] = d2_q;
    end else if (cbc_s) begin
      region_s = tcpb_pkg::REG_EDGE_BC;
      den_s    = den_bc_s;
      degen_s  = nonpos(den_s);
      num_s[1] = e56_q;
      num_s[2] = e43_q;
    end else begin
      degen_s = (n_q == '0);
      if (n_q[WIDE_W-1]) begin
        den_s    = -n_q;
        num_s[0] = -ua_q;
        num_s[1] = -cv_q;
        num_s[2] = -cw_q;
      end else begin
        den_s    = n_q;
        num_s[0] = ua_q;
        num_s[1] = cv_q;
        num_s[2] = cw_q;
      end
    end
    // zero or negative divisor: force 1,0,0
    if (degen_s) begin
      den_s    = WIDE_W'(1);
      num_s[0] = WIDE_W'(1);
      num_s[1] = '0;
      num_s[2] = '0;
    end
  end

  tcpb_pkg::region_e        region_q;
  logic                     degen_q;
  logic [DEN_W-1:0]         den_q;
  logic signed [WIDE_W-1:0] num_q [NLANE];

  always_ff @(posedge clk_i) begin
    if (en_i[STG_SEL]) begin
      region_q <= region_s;
      degen_q  <= degen_s;
      den_q    <= den_s[DEN_W-1:0];
      for (int l = 0; l < NLANE; l++) begin
        num_q[l] <= num_s[l];
      end
    end
  end

  // Clamp each numerator into [0, den]
  logic [WIDE_W-1:0] den_ext;
  logic [WIDE_W-1:0] clp_s [NLANE];

  assign den_ext = {{(WIDE_W-DEN_W){1'b0}}, den_q};

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      if (num_q[l][WIDE_W-1]) begin
        clp_s[l] = '0;
      end else if ($unsigned(num_q[l]) > den_ext) begin
        clp_s[l] = den_ext;
      end else begin
        clp_s[l] = $unsigned(num_q[l]);
      end
    end
  end

  tcpb_pkg::div_in_t out_q;

  always_ff @(posedge clk_i) begin
    if (en_i[STG_CLP]) begin
      out_q.region <= region_q;
      out_q.degen  <= degen_q;
      out_q.den    <= den_q;
      for (int l = 0; l < NLANE; l++) begin
        out_q.rem[l] <= clp_s[l][REM_W-1:0];
      end
    end
  end

  assign out_o = out_q;

endmodule

[hw/rtl/tcpb_div.sv]
module tcpb_div (
  input  logic                           clk_i,
  input  logic [tcpb_pkg::DIV_STG-1:0]   en_i,
  input  tcpb_pkg::div_in_t              in_i,
  output tcpb_pkg::out_item_t            out_o
);

  localparam int DEN_W = tcpb_pkg::DEN_W;
  localparam int REM_W = tcpb_pkg::REM_W;
  localparam int Q_W   = tcpb_pkg::Q_W;
  localparam int NSTG  = tcpb_pkg::DIV_STG;
  localparam int NLANE = tcpb_pkg::NUM_LANE;

  logic [REM_W-1:0]  rem_q  [NSTG][NLANE];
  logic [Q_W-1:0]    q_q    [NSTG][NLANE];
  logic [DEN_W-1:0]  den_q  [NSTG];
  tcpb_pkg::region_e region_q [NSTG];
  logic              degen_q  [NSTG];

  // Stage inputs: trial remainder, quotient so far, side info
  logic [REM_W-1:0]  t_w    [NSTG][NLANE];
  logic [Q_W-1:0]    qp_w   [NSTG][NLANE];
  logic [DEN_W-1:0]  den_w  [NSTG];
  tcpb_pkg::region_e region_w [NSTG];
  logic              degen_w  [NSTG];

  for (genvar j = 0; j < NSTG; j++) begin : g_stg
    if (j == 0) begin : g_head
      // Top quotient bit: numerator never exceeds den, so no shift
      for (genvar l = 0; l < NLANE; l++) begin : g_lane
        assign t_w[j][l]  = in_i.rem[l];
        assign qp_w[j][l] = '0;
      end
      assign den_w[j]    = in_i.den;
      assign region_w[j] = in_i.region;
      assign degen_w[j]  = in_i.degen;
    end else begin : g_body
      for (genvar l = 0; l < NLANE; l++) begin : g_lane
        assign t_w[j][l]  = {rem_q[j-1][l][REM_W-2:0], 1'b0};
        assign qp_w[j][l] = q_q[j-1][l];
      end
      assign den_w[j]    = den_q[j-1];
      assign region_w[j] = region_q[j-1];
      assign degen_w[j]  = degen_q[j-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        den_q[j]    <= den_w[j];
        region_q[j] <= region_w[j];
        degen_q[j]  <= degen_w[j];
        for (int l = 0; l < NLANE; l++) begin
          if (t_w[j][l] >= REM_W'(den_w[j])) begin
            rem_q[j][l] <= t_w[j][l] - REM_W'(den_w[j]);
            q_q[j][l]   <= {qp_w[j][l][Q_W-2:0], 1'b1};
          end else begin
            rem_q[j][l] <= t_w[j][l];
            q_q[j][l]   <= {qp_w[j][l][Q_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign out_o.weight_a   = q_q[NSTG-1][0];
  assign out_o.weight_b   = q_q[NSTG-1][1];
  assign out_o.weight_c   = q_q[NSTG-1][2];
  assign out_o.region     = region_q[NSTG-1];
  assign out_o.degenerate = degen_q[NSTG-1];

endmodule

[hw/rtl/triangle_closest_point_barycentric_unit.sv]
// Channel   Valid / Ready              Payload                 Beat
// input     in_valid_i / in_ready_o    in_data_i (in_item_t)   triangle a,b,c and point p
// output    out_valid_o / out_ready_i  out_data_o (out_item_t) weights, region, degenerate
//
// One beat enters per cycle when nothing stalls; each result passes through
// 6 geometry stages, then 16 restoring divide steps (one quotient bit per
// stage, three lanes side by side for the three weights).
// Reset clears only the stage valid bits; data registers carry no reset.
// A stall holds the last stage; stages behind it keep filling any bubbles, so
// input beats are taken while a result waits until every stage is full.

module triangle_closest_point_barycentric_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tcpb_pkg::in_item_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output tcpb_pkg::out_item_t   out_data_o
);

  localparam int NSTG  = tcpb_pkg::NUM_STG;
  localparam int GSTG  = tcpb_pkg::GEOM_STG;

  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] v_d;
  logic [NSTG-1:0] en;

  // A stage may load when any stage from it to the output is empty,
  // or the output beat is being taken.
  for (genvar k = 0; k < NSTG; k++) begin : g_en
    assign en[k] = out_ready_i || !(&v_q[NSTG-1:k]);
  end

  // Advance valid bits together with the data
  assign v_d = {v_q[NSTG-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (en & v_d) | (~en & v_q);
    end
  end

  tcpb_pkg::div_in_t div_in;

  // Differences, products, sums, region tests, selection, clamp
  tcpb_geom u_geom (
    .clk_i (clk_i),
    .en_i  (en[GSTG-1:0]),
    .in_i  (in_data_i),
    .out_o (div_in)
  );

  // Three 16-step divider lanes; the last stage is the output register
  tcpb_div u_div (
    .clk_i (clk_i),
    .en_i  (en[NSTG-1:GSTG]),
    .in_i  (div_in),
    .out_o (out_data_o)
  );

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NSTG-1];

endmodule

[hw/rtl/tcpb_checker.sv]
`include "assert_macros.svh"

module tcpb_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input tcpb_pkg::in_item_t   in_data_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input tcpb_pkg::out_item_t  out_data_o
);

  // Hold a stalled result beat
  `TCPB_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))

  `TCPB_ASSERT_OUT(a_weight_range, out_data_o.weight_a <= 16'h8000 && out_data_o.weight_b <= 16'h8000 && out_data_o.weight_c <= 16'h8000)

  `TCPB_ASSERT_OUT(a_degen_weights, !out_data_o.degenerate || (out_data_o.weight_a == 16'h8000 && out_data_o.weight_b == '0 && out_data_o.weight_c == '0))

  `TCPB_ASSERT_OUT(a_vertex_a, out_data_o.region != tcpb_pkg::REG_VERT_A || (!out_data_o.degenerate && out_data_o.weight_a == 16'h8000 && out_data_o.weight_b == '0))

endmodule

bind triangle_closest_point_barycentric_unit tcpb_checker u_tcpb_checker (.*);

[tb/tb.sv]
module tb;
  import tcpb_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int PIPE_LAT    = 22;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  // Triangles waiting to be offered, and the results they must produce.
  in_item_t  tri_q[$];
  out_item_t weights_q[$];

  int  n_errors = 0;
  bit  stim_done = 1'b0;
  bit  calm_phase = 1'b0;     // no idling on either side
  int  sink_hold = 0;         // receiver hold-off, counted down by the monitor
  bit  src_pause = 1'b0;      // sender waits for the pipe to drain

  always #HALF_PERIOD clk_i = ~clk_i;

  triangle_closest_point_barycentric_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Clamp num into [0,den] and scale to Q1.15, truncating toward zero.
  function automatic logic [15:0] scale_q15(longint num, longint den);
    if (num < 0) num = 0;
    if (num > den) num = den;
    return 16'((num * 32768) / den);
  endfunction

  function automatic int sign_of(longint x);
    return (x > 0) - (x < 0);
  endfunction

  // Closest point of triangle abc to p, as weights and matched region.
  function automatic out_item_t closest_weights(in_item_t t);
    longint ax, ay, bx, by, cx, cy, px, py;
    longint abx, aby, acx, acy, apx, apy, bpx, bpy, cpx, cpy;
    longint d1, d2, d3, d4, d5, d6, nrm, cv, cw, ua, den, num;
    out_item_t r;
    ax = t.ax; ay = t.ay; bx = t.bx; by = t.by_coord;
    cx = t.cx; cy = t.cy; px = t.px; py = t.py;
    abx = bx - ax; aby = by - ay; acx = cx - ax; acy = cy - ay;
    apx = px - ax; apy = py - ay; bpx = px - bx; bpy = py - by;
    cpx = px - cx; cpy = py - cy;
    d1 = abx * apx + aby * apy;
    d2 = acx * apx + acy * apy;
    d3 = abx * bpx + aby * bpy;
    d4 = acx * bpx + acy * bpy;
    d5 = abx * cpx + aby * cpy;
    d6 = acx * cpx + acy * cpy;
    nrm = abx * acy - aby * acx;
    cv  = apx * acy - apy * acx;
    cw  = abx * apy - aby * apx;
    ua  = nrm - cv - cw;
    r = '0;
    if (d1 <= 0 && d2 <= 0) begin
      r.region = REG_VERT_A; r.weight_a = 16'h8000;
    end else if (d3 >= 0 && d4 <= d3) begin
      r.region = REG_VERT_B; r.weight_b = 16'h8000;
    end else if (sign_of(nrm) * sign_of(cw) <= 0 && d1 >= 0 && d3 <= 0) begin
      r.region = REG_EDGE_AB;
      den = d1 - d3;
      if (den <= 0) begin
        r.degenerate = 1'b1; r.weight_a = 16'h8000;
      end else begin
        r.weight_a = scale_q15(den - d1, den); r.weight_b = scale_q15(d1, den);
      end
    end else if (d6 >= 0 && d5 <= d6) begin
      r.region = REG_VERT_C; r.weight_c = 16'h8000;
    end else if (sign_of(nrm) * sign_of(cv) <= 0 && d2 >= 0 && d6 <= 0) begin
      r.region = REG_EDGE_AC;
      den = d2 - d6;
      if (den <= 0) begin
        r.degenerate = 1'b1; r.weight_a = 16'h8000;
      end else begin
        r.weight_a = scale_q15(den - d2, den); r.weight_c = scale_q15(d2, den);
      end
    end else if (sign_of(nrm) * sign_of(ua) <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0) begin
      r.region = REG_EDGE_BC;
      num = d4 - d3;
      den = num + d5 - d6;
      if (den <= 0) begin
        r.degenerate = 1'b1; r.weight_a = 16'h8000;
      end else begin
        r.weight_b = scale_q15(den - num, den); r.weight_c = scale_q15(num, den);
      end
    end else begin
      r.region = REG_INTERIOR;
      if (nrm == 0) begin
        r.degenerate = 1'b1; r.weight_a = 16'h8000;
      end else begin
        if (nrm < 0) begin
          nrm = -nrm; cv = -cv; cw = -cw; ua = -ua;
        end
        r.weight_a = scale_q15(ua, nrm);
        r.weight_b = scale_q15(cv, nrm);
        r.weight_c = scale_q15(cw, nrm);
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] rand_coord(int spread);
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'($signed($urandom_range(0, 2 * spread)) - spread);
      2:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(0, 64)) - 32);
    endcase
  endfunction

  function automatic in_item_t rand_tri();
    in_item_t t;
    int spread;
    spread = $urandom_range(0, 1) ? 2048 : 32767;
    t.ax = rand_coord(spread); t.ay = rand_coord(spread);
    t.bx = rand_coord(spread); t.by_coord = rand_coord(spread);
    t.cx = rand_coord(spread); t.cy = rand_coord(spread);
    t.px = rand_coord(spread); t.py = rand_coord(spread);
    // Snap some vertices together or onto a line to reach degenerate cases.
    case ($urandom_range(0, 9))
      0: begin t.bx = t.ax; t.by_coord = t.ay; end
      1: begin t.cx = t.ax; t.cy = t.ay; end
      2: begin t.cx = t.bx; t.cy = t.by_coord; end
      3: begin t.ay = t.by_coord; t.cy = t.by_coord; end
      default: ;
    endcase
    return t;
  endfunction

  function automatic in_item_t mk_tri(int ax, int ay, int bx, int by, int cx,
                                      int cy, int px, int py);
    in_item_t t;
    t.ax = 16'(ax); t.ay = 16'(ay); t.bx = 16'(bx); t.by_coord = 16'(by);
    t.cx = 16'(cx); t.cy = 16'(cy); t.px = 16'(px); t.py = 16'(py);
    return t;
  endfunction

  // Append a triangle to the pending queue.
  task automatic queue_tri(in_item_t t);
    tri_q.insert(tri_q.size(), t);
  endtask

  // Driver: offer the head of the queue; advance on a beat, idle at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        weights_q.insert(weights_q.size(), closest_weights(in_data_i));
        void'(tri_q.pop_front());
      end
      if (in_valid_i && !in_ready_o) begin
        // hold the beat until it is taken
      end else if (tri_q.size() != 0 && !src_pause &&
                   (calm_phase || $urandom_range(0, 99) >= 27)) begin
        in_valid_i <= 1'b1;
        in_data_i  <= tri_q[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: compare each result beat with the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t exp_w;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (weights_q.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, out_data_o);
          n_errors++;
        end else begin
          exp_w = weights_q.pop_front();
          if (out_data_o.weight_a !== exp_w.weight_a ||
              out_data_o.weight_b !== exp_w.weight_b ||
              out_data_o.weight_c !== exp_w.weight_c ||
              out_data_o.region !== exp_w.region ||
              out_data_o.degenerate !== exp_w.degenerate) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_w, out_data_o);
            n_errors++;
          end
        end
      end
      if (sink_hold > 0) begin
        sink_hold <= sink_hold - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm_phase || ($urandom_range(0, 99) >= 27);
      end
    end
  end

  task automatic wait_drained();
    while (tri_q.size() != 0 || in_valid_i || weights_q.size() != 0) @(posedge clk_i);
  endtask

  // With the sender paused, wait until every accepted beat has its result.
  task automatic wait_results();
    @(posedge clk_i);
    while (in_valid_i || weights_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: vertex, edge and interior regions, extremes, degenerate shapes.
    queue_tri(mk_tri(0, 0, 256, 0, 0, 256, -100, -100));
    queue_tri(mk_tri(0, 0, 256, 0, 0, 256, 400, -10));
    queue_tri(mk_tri(0, 0, 256, 0, 0, 256, 100, -50));
    queue_tri(mk_tri(0, 0, 256, 0, 0, 256, -10, 400));
    queue_tri(mk_tri(0, 0, 256, 0, 0, 256, -50, 100));
    queue_tri(mk_tri(0, 0, 256, 0, 0, 256, 200, 200));
    queue_tri(mk_tri(0, 0, 256, 0, 0, 256, 60, 70));
    queue_tri(mk_tri(0, 0, 0, 256, 256, 0, 60, 70));
    queue_tri(mk_tri(5, 5, 5, 5, 5, 5, 5, 5));
    queue_tri(mk_tri(0, 0, 0, 0, 100, 0, 50, 9));
    queue_tri(mk_tri(0, 0, 100, 0, 100, 0, 150, 9));
    queue_tri(mk_tri(0, 0, 100, 0, 200, 0, 50, 9));
    queue_tri(mk_tri(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767));
    queue_tri(mk_tri(32767, 32767, -32768, 32767, 32767, -32768, 0, 0));
    queue_tri(mk_tri(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767));
    queue_tri(mk_tri(-1, -1, -1, -1, -1, -1, 0, 0));
    queue_tri(mk_tri(-32768, -32768, -32768, -32768, 32767, 32767, 0, 0));
    wait_drained();
    // Random triangles, with a calm stretch in the middle.
    for (int n = 0; n < 900; n++) begin
      calm_phase = (n >= 300 && n < 450);
      if (n == 600) begin
        sink_hold = 120;         // long receiver stall; sender keeps offering
        for (int k = 0; k < 60; k++) queue_tri(rand_tri());
      end
      if (n == 700) begin
        src_pause = 1'b1;        // let every expected result come out
        wait_results();
        src_pause = 1'b0;
      end
      queue_tri(rand_tri());
      while (tri_q.size() > 8) @(posedge clk_i);
    end
    wait_drained();
    repeat (PIPE_LAT + 10) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
